[rtl/segment_circle_collision_core_defines.svh]
// ----------------------------------------------------------------------------
// Segment circle collision core assertion macros
// Shared property macros for the collision pipeline.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CIRCLE_COLLISION_CORE_DEFINES_SVH
`define SEGMENT_CIRCLE_COLLISION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and quiet while rst is high.
`define SCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc: same-cycle property failed");
// Next-cycle implication, sampled on clk and quiet while rst is high.
`define SCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc: next-cycle property failed");
`else
`define SCC_ASSERT_IMP(lbl, ante, cons)
`define SCC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// Segment circle collision package
// Widths and fixed-point constants shared by the core and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // Default coordinate width, signed Q8.8.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Radius and depth are unsigned Q7.8 in 15 bits.
  localparam int unsigned RADIUS_W = 15;

  // Normal components are signed Q1.14.
  localparam int unsigned NORM_W = 16;

  // Fraction bits of the projection parameter t.
  localparam int unsigned FRAC_BITS = 30;

  // Unit length in Q1.14.
  localparam int unsigned NORM_ONE = 16384;

endpackage

`default_nettype wire

[rtl/scc_in_if.sv]
// ----------------------------------------------------------------------------
// Segment circle collision input channel
// Valid/ready channel carrying one segment and one circle per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_in_if #(
  parameter int unsigned COORD_BITS = scc_pkg::COORD_BITS_DEF
) ();
  import scc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [RADIUS_W-1:0]   radius;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           center_x, center_y, radius,
    input  ready
  );

  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           center_x, center_y, radius,
    output ready
  );

endinterface

`default_nettype wire

[rtl/scc_out_if.sv]
// ----------------------------------------------------------------------------
// Segment circle collision result channel
// Valid/ready channel carrying one collision result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_out_if #(
  parameter int unsigned COORD_BITS = scc_pkg::COORD_BITS_DEF
) ();
  import scc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         center_on_segment;
  logic        [RADIUS_W-1:0]   depth;
  logic signed [NORM_W-1:0]     normal_x;
  logic signed [NORM_W-1:0]     normal_y;
  logic signed [COORD_BITS-1:0] contact_x;
  logic signed [COORD_BITS-1:0] contact_y;

  modport source (
    output valid, hit, center_on_segment, depth, normal_x, normal_y,
           contact_x, contact_y,
    input  ready
  );

  modport sink (
    input  valid, hit, center_on_segment, depth, normal_x, normal_y,
           contact_x, contact_y,
    output ready
  );

endinterface

`default_nettype wire

[rtl/segment_circle_collision_core.sv]
// ----------------------------------------------------------------------------
// Segment circle collision core
// Closest point of a segment to a circle center, hit test, depth, normal.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Beat contents
//   seg_in    in   segment start/end, circle center (Q8.8), radius (Q7.8)
//   res_out   out  hit, center_on_segment, depth, normal (Q1.14), contact
//
// One beat is taken per cycle while the pipeline is not stalled. Its depth
// comes from a 30-stage restoring divider for the projection fraction, a
// 29-stage square root for the distance and two 15-stage dividers for the
// normal.
// Reset (rst, synchronous) clears only the valid bits of the stages.
// When a result waits on res_out and ready is low, every stage holds and
// seg_in.ready drops in the same cycle; nothing is lost or repeated.
//
`default_nettype none

`include "segment_circle_collision_core_defines.svh"

module segment_circle_collision_core #(
  parameter int unsigned COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  scc_in_if.sink    seg_in,
  scc_out_if.source res_out
);
  import scc_pkg::*;

  // Working width: wide coordinates are taken by their low 30 bits.
  localparam int WB  = (COORD_BITS > 30) ? 30 : COORD_BITS;
  // Differences of two coordinates.
  localparam int DW  = WB + 1;
  // Products of two differences.
  localparam int PW  = 2 * DW;
  // Dot products.
  localparam int SW  = PW + 1;
  localparam int SW1 = SW + 1;
  // Projection divider remainder.
  localparam int RW  = PW + 1;
  // Magnitude times fraction.
  localparam int MW  = DW + FRAC_BITS;
  // Square root: the radicand is the squared distance shifted by 28.
  localparam int XW  = 58;
  localparam int ISQ = 29;
  localparam int SQW = 29;
  // Normal divider: numerator is a 15-bit magnitude shifted by 28.
  localparam int NW  = 44;
  localparam int NQ  = 15;

  // Stage numbering: 3 front stages, FRAC_BITS+1 divider entries,
  // 4 point stages, ISQ+1 root entries, NQ+1 normal entries, output.
  localparam int NST = 3 + (FRAC_BITS + 1) + 4 + (ISQ + 1) + (NQ + 1) + 1;

  typedef struct packed {
    logic signed [WB-1:0]       ax, ay, bx, by, cx, cy;
    logic signed [DW-1:0]       dx, dy;
    logic        [RADIUS_W-1:0] r;
  } geom_t;

  typedef struct packed {
    logic                       hit;
    logic                       zero;
    logic signed [WB-1:0]       px, py;
    logic        [RADIUS_W-1:0] r;
    logic        [RADIUS_W-1:0] mx, my;
    logic                       nx, ny;
  } root_t;

  typedef struct packed {
    logic                       hit;
    logic                       zero;
    logic        [RADIUS_W-1:0] depth;
    logic signed [WB-1:0]       px, py;
    logic                       nx, ny;
  } norm_t;

  // The whole pipeline advances together unless a result is stuck at the
  // output register.
  logic           en;
  logic [NST-1:0] vld;

  assign en           = ~vld[NST-1] | res_out.ready;
  assign seg_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], seg_in.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: register the beat and form the edge and center differences.
  // --------------------------------------------------------------------------
  logic signed [WB-1:0] i_ax, i_ay, i_bx, i_by, i_cx, i_cy;

  assign i_ax = seg_in.seg_start_x[WB-1:0];
  assign i_ay = seg_in.seg_start_y[WB-1:0];
  assign i_bx = seg_in.seg_end_x[WB-1:0];
  assign i_by = seg_in.seg_end_y[WB-1:0];
  assign i_cx = seg_in.center_x[WB-1:0];
  assign i_cy = seg_in.center_y[WB-1:0];

  geom_t                a_g;
  logic signed [DW-1:0] a_wx, a_wy;

  always_ff @(posedge clk) begin
    if (en) begin
      a_g.ax <= i_ax;
      a_g.ay <= i_ay;
      a_g.bx <= i_bx;
      a_g.by <= i_by;
      a_g.cx <= i_cx;
      a_g.cy <= i_cy;
      a_g.dx <= DW'(i_bx) - DW'(i_ax);
      a_g.dy <= DW'(i_by) - DW'(i_ay);
      a_g.r  <= seg_in.radius;
      a_wx   <= DW'(i_cx) - DW'(i_ax);
      a_wy   <= DW'(i_cy) - DW'(i_ay);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: the four products of the two dot products.
  // --------------------------------------------------------------------------
  geom_t                b_g;
  logic signed [PW-1:0] b_pwx, b_pwy, b_pdx, b_pdy;

  always_ff @(posedge clk) begin
    if (en) begin
      b_g   <= a_g;
      b_pwx <= PW'(a_wx) * PW'(a_g.dx);
      b_pwy <= PW'(a_wy) * PW'(a_g.dy);
      b_pdx <= PW'(a_g.dx) * PW'(a_g.dx);
      b_pdy <= PW'(a_g.dy) * PW'(a_g.dy);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: (C-S).(E-S) and |E-S|^2.
  // --------------------------------------------------------------------------
  geom_t                c_g;
  logic signed [SW-1:0] c_dota, c_len2;

  always_ff @(posedge clk) begin
    if (en) begin
      c_g    <= b_g;
      c_dota <= SW'(b_pwx) + SW'(b_pwy);
      c_len2 <= SW'(b_pdx) + SW'(b_pdy);
    end
  end

  // --------------------------------------------------------------------------
  // Projection divider: t = floor(dotA * 2^30 / len2), one bit per stage.
  // Entry 0 also decides which endpoint clamps, since (C-E).(E-S) equals
  // dotA - len2.
  // --------------------------------------------------------------------------
  logic signed [SW1-1:0] c_dotb;

  assign c_dotb = SW1'(c_dota) - SW1'(c_len2);

  geom_t                dv_g   [0:FRAC_BITS];
  logic                 dv_sa  [0:FRAC_BITS];
  logic                 dv_sb  [0:FRAC_BITS];
  logic [RW-1:0]        dv_rem [0:FRAC_BITS];
  logic [PW-1:0]        dv_den [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q   [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_g[0]   <= c_g;
      dv_sa[0]  <= (c_dota <= 0);
      dv_sb[0]  <= (c_dotb >= 0);
      dv_rem[0] <= RW'(c_dota[PW-1:0]);
      dv_den[0] <= c_len2[PW-1:0];
      dv_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_frac
    logic [RW-1:0] rem_sh;
    logic          take;

    assign rem_sh = {dv_rem[k][RW-2:0], 1'b0};
    assign take   = (rem_sh >= RW'(dv_den[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        dv_g[k+1]   <= dv_g[k];
        dv_sa[k+1]  <= dv_sa[k];
        dv_sb[k+1]  <= dv_sb[k];
        dv_den[k+1] <= dv_den[k];
        dv_rem[k+1] <= take ? (rem_sh - RW'(dv_den[k])) : rem_sh;
        dv_q[k+1]   <= {dv_q[k][FRAC_BITS-2:0], take};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: scale |E-S| by t.
  // --------------------------------------------------------------------------
  geom_t         m_g;
  logic          m_sa, m_sb;
  logic [MW-1:0] m_prx, m_pry;
  logic [DW-1:0] f_magx, f_magy;

  assign f_magx = dv_g[FRAC_BITS].dx[DW-1] ? DW'(-dv_g[FRAC_BITS].dx) : DW'(dv_g[FRAC_BITS].dx);
  assign f_magy = dv_g[FRAC_BITS].dy[DW-1] ? DW'(-dv_g[FRAC_BITS].dy) : DW'(dv_g[FRAC_BITS].dy);

  always_ff @(posedge clk) begin
    if (en) begin
      m_g   <= dv_g[FRAC_BITS];
      m_sa  <= dv_sa[FRAC_BITS];
      m_sb  <= dv_sb[FRAC_BITS];
      m_prx <= MW'(f_magx) * MW'(dv_q[FRAC_BITS]);
      m_pry <= MW'(f_magy) * MW'(dv_q[FRAC_BITS]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage P: round half away from zero and pick the closest point.
  // --------------------------------------------------------------------------
  logic [MW-1:0]        m_rndx, m_rndy;
  logic [DW-1:0]        m_qx, m_qy;
  logic signed [DW-1:0] m_prjx, m_prjy;
  logic signed [WB-1:0] m_selx, m_sely;

  assign m_rndx = m_prx + (MW'(1) << (FRAC_BITS - 1));
  assign m_rndy = m_pry + (MW'(1) << (FRAC_BITS - 1));
  assign m_qx   = m_rndx[FRAC_BITS +: DW];
  assign m_qy   = m_rndy[FRAC_BITS +: DW];
  assign m_prjx = m_g.dx[DW-1] ? (DW'(m_g.ax) - signed'(m_qx)) : (DW'(m_g.ax) + signed'(m_qx));
  assign m_prjy = m_g.dy[DW-1] ? (DW'(m_g.ay) - signed'(m_qy)) : (DW'(m_g.ay) + signed'(m_qy));

  always_comb begin
    if (m_sa) begin
      m_selx = m_g.ax;
      m_sely = m_g.ay;
    end else if (m_sb) begin
      m_selx = m_g.bx;
      m_sely = m_g.by;
    end else begin
      m_selx = m_prjx[WB-1:0];
      m_sely = m_prjy[WB-1:0];
    end
  end

  logic signed [WB-1:0]       p_px, p_py, p_cx, p_cy;
  logic        [RADIUS_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_px <= m_selx;
      p_py <= m_sely;
      p_cx <= m_g.cx;
      p_cy <= m_g.cy;
      p_r  <= m_g.r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: offset from the closest point to the center. An offset of
  // 2^15 or more on either axis is always a miss, so only 15 bits go on.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]    p_ex, p_ey;
  logic        [DW-1:0]    p_magx, p_magy;

  assign p_ex   = DW'(p_cx) - DW'(p_px);
  assign p_ey   = DW'(p_cy) - DW'(p_py);
  assign p_magx = p_ex[DW-1] ? DW'(-p_ex) : DW'(p_ex);
  assign p_magy = p_ey[DW-1] ? DW'(-p_ey) : DW'(p_ey);

  logic                       e_big;
  logic        [RADIUS_W-1:0] e_mx, e_my;
  logic                       e_nx, e_ny;
  logic signed [WB-1:0]       e_px, e_py;
  logic        [RADIUS_W-1:0] e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_big <= (|(p_magx >> RADIUS_W)) | (|(p_magy >> RADIUS_W));
      e_mx  <= RADIUS_W'(p_magx);
      e_my  <= RADIUS_W'(p_magy);
      e_nx  <= p_ex[DW-1];
      e_ny  <= p_ey[DW-1];
      e_px  <= p_px;
      e_py  <= p_py;
      e_r   <= p_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q: squares of the offsets and of the radius.
  // --------------------------------------------------------------------------
  logic                       q_big;
  logic [2*RADIUS_W-1:0]      q_sqx, q_sqy, q_rr;
  logic        [RADIUS_W-1:0] q_mx, q_my, q_r;
  logic                       q_nx, q_ny;
  logic signed [WB-1:0]       q_px, q_py;

  always_ff @(posedge clk) begin
    if (en) begin
      q_big <= e_big;
      q_sqx <= (2*RADIUS_W)'(e_mx) * (2*RADIUS_W)'(e_mx);
      q_sqy <= (2*RADIUS_W)'(e_my) * (2*RADIUS_W)'(e_my);
      q_rr  <= (2*RADIUS_W)'(e_r) * (2*RADIUS_W)'(e_r);
      q_mx  <= e_mx;
      q_my  <= e_my;
      q_r   <= e_r;
      q_nx  <= e_nx;
      q_ny  <= e_ny;
      q_px  <= e_px;
      q_py  <= e_py;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of dist2 * 2^28, one result bit per stage. Entry 0 makes
  // the exact hit compare; the radicand only matters on a hit, where
  // dist2 is below 2^30.
  // --------------------------------------------------------------------------
  logic [2*RADIUS_W:0] q_d2;

  assign q_d2 = (2*RADIUS_W+1)'(q_sqx) + (2*RADIUS_W+1)'(q_sqy);

  root_t         rt_p [0:ISQ];
  logic [XW-1:0] rt_x [0:ISQ];
  logic [XW-1:0] rt_r [0:ISQ];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_p[0].hit  <= ~q_big & (q_d2 <= (2*RADIUS_W+1)'(q_rr));
      rt_p[0].zero <= (q_d2 == '0);
      rt_p[0].px   <= q_px;
      rt_p[0].py   <= q_py;
      rt_p[0].r    <= q_r;
      rt_p[0].mx   <= q_mx;
      rt_p[0].my   <= q_my;
      rt_p[0].nx   <= q_nx;
      rt_p[0].ny   <= q_ny;
      rt_x[0]      <= {q_d2[2*RADIUS_W-1:0], 28'b0};
      rt_r[0]      <= '0;
    end
  end

  for (genvar k = 0; k < ISQ; k++) begin : g_root
    localparam logic [XW-1:0] BIT = XW'(1) << (56 - 2 * k);
    logic [XW-1:0] trial;
    logic          take;

    assign trial = rt_r[k] + BIT;
    assign take  = (rt_x[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rt_p[k+1] <= rt_p[k];
        rt_x[k+1] <= take ? (rt_x[k] - trial) : rt_x[k];
        rt_r[k+1] <= take ? ((rt_r[k] >> 1) + BIT) : (rt_r[k] >> 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normal dividers: round(|offset| * 2^28 / s), 15 quotient bits, one per
  // stage. Entry 0 also forms the depth from the rounded distance.
  // --------------------------------------------------------------------------
  logic [SQW-1:0]      s_root;
  logic [SQW:0]        s_dsum;
  logic [RADIUS_W-1:0] s_dist;

  assign s_root = rt_r[ISQ][SQW-1:0];
  assign s_dsum = (SQW+1)'(s_root) + (SQW+1)'(8192);
  assign s_dist = s_dsum[14 +: RADIUS_W];

  norm_t          nd_p  [0:NQ];
  logic [NW-1:0]  nd_rx [0:NQ];
  logic [NW-1:0]  nd_ry [0:NQ];
  logic [NQ-1:0]  nd_qx [0:NQ];
  logic [NQ-1:0]  nd_qy [0:NQ];
  logic [SQW-1:0] nd_s  [0:NQ];

  always_ff @(posedge clk) begin
    if (en) begin
      nd_p[0].hit   <= rt_p[ISQ].hit;
      nd_p[0].zero  <= rt_p[ISQ].zero;
      nd_p[0].depth <= rt_p[ISQ].zero ? rt_p[ISQ].r : (rt_p[ISQ].r - s_dist);
      nd_p[0].px    <= rt_p[ISQ].px;
      nd_p[0].py    <= rt_p[ISQ].py;
      nd_p[0].nx    <= rt_p[ISQ].nx;
      nd_p[0].ny    <= rt_p[ISQ].ny;
      nd_rx[0]      <= NW'({rt_p[ISQ].mx, 28'b0}) + NW'(s_root[SQW-1:1]);
      nd_ry[0]      <= NW'({rt_p[ISQ].my, 28'b0}) + NW'(s_root[SQW-1:1]);
      nd_qx[0]      <= '0;
      nd_qy[0]      <= '0;
      nd_s[0]       <= s_root;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_norm
    logic [NW-1:0] dsh;
    logic          takex, takey;

    assign dsh   = NW'(nd_s[k]) << (NQ - 1 - k);
    assign takex = (nd_rx[k] >= dsh);
    assign takey = (nd_ry[k] >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        nd_p[k+1]  <= nd_p[k];
        nd_s[k+1]  <= nd_s[k];
        nd_rx[k+1] <= takex ? (nd_rx[k] - dsh) : nd_rx[k];
        nd_ry[k+1] <= takey ? (nd_ry[k] - dsh) : nd_ry[k];
        nd_qx[k+1] <= {nd_qx[k][NQ-2:0], takex};
        nd_qy[k+1] <= {nd_qy[k][NQ-2:0], takey};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A miss clears every field, and a center lying on the
  // segment keeps the normal at zero.
  // --------------------------------------------------------------------------
  logic [NQ-1:0]              f_nx, f_ny;
  logic                       o_hit, o_zero;
  logic        [RADIUS_W-1:0] o_depth;
  logic signed [NORM_W-1:0]   o_nx, o_ny;
  logic signed [WB-1:0]       o_px, o_py;

  assign f_nx = (nd_qx[NQ] > NQ'(NORM_ONE)) ? NQ'(NORM_ONE) : nd_qx[NQ];
  assign f_ny = (nd_qy[NQ] > NQ'(NORM_ONE)) ? NQ'(NORM_ONE) : nd_qy[NQ];

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit  <= nd_p[NQ].hit;
      o_zero <= nd_p[NQ].hit & nd_p[NQ].zero;
      if (nd_p[NQ].hit) begin
        o_depth <= nd_p[NQ].depth;
        o_px    <= nd_p[NQ].px;
        o_py    <= nd_p[NQ].py;
      end else begin
        o_depth <= '0;
        o_px    <= '0;
        o_py    <= '0;
      end
      if (nd_p[NQ].hit && !nd_p[NQ].zero) begin
        o_nx <= nd_p[NQ].nx ? -signed'(NORM_W'(f_nx)) : signed'(NORM_W'(f_nx));
        o_ny <= nd_p[NQ].ny ? -signed'(NORM_W'(f_ny)) : signed'(NORM_W'(f_ny));
      end else begin
        o_nx <= '0;
        o_ny <= '0;
      end
    end
  end

  assign res_out.valid             = vld[NST-1];
  assign res_out.hit               = o_hit;
  assign res_out.center_on_segment = o_zero;
  assign res_out.depth             = o_depth;
  assign res_out.normal_x          = o_nx;
  assign res_out.normal_y          = o_ny;
  assign res_out.contact_x         = COORD_BITS'(o_px);
  assign res_out.contact_y         = COORD_BITS'(o_py);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SCC_ASSERT_IMP(a_miss_zero, res_out.valid && !res_out.hit, o_depth == '0 && o_nx == '0 && o_ny == '0 && o_px == '0 && o_py == '0)
  `SCC_ASSERT_IMP(a_on_seg, res_out.valid && res_out.center_on_segment, res_out.hit && o_nx == '0 && o_ny == '0)
  `SCC_ASSERT_IMP(a_norm_range, res_out.valid && res_out.hit, o_nx <= 16'sd16384 && o_nx >= -16'sd16384 && o_ny <= 16'sd16384 && o_ny >= -16'sd16384)
  `SCC_ASSERT_NXT(a_stall_hold, vld[NST-1] && !res_out.ready, vld[NST-1] && $stable(o_depth) && $stable(o_px) && $stable(o_py))
  `SCC_ASSERT_NXT(a_inner_hold, vld[NST-2] && !en, vld[NST-2])

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Segment circle collision core testbench
// Streams segment/circle beats through the core under several idling phases
// and checks each result beat against a bit-accurate predictor held here.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  // Allow a margin past the core's latency for the drain at the end.
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [CB-1:0]   sx, sy, ex, ey, cx, cy;
    logic [RADIUS_W-1:0]    r;
  } probe_t;

  typedef struct packed {
    logic                   hit, on_seg;
    logic [RADIUS_W-1:0]    depth;
    logic signed [NORM_W-1:0] nx, ny;
    logic signed [CB-1:0]   px, py;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scc_in_if  #(.COORD_BITS(CB)) seg_in ();
  scc_out_if #(.COORD_BITS(CB)) res_out ();

  segment_circle_collision_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .seg_in(seg_in.sink), .res_out(res_out.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  probe_t   pending_probes[$];
  contact_t expected_contacts[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       recv_hold = 1'b0;
  bit       stim_done = 1'b0;

  // Integer square root, floor, by the bit-pair method.
  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Predicts the collision result for one probe beat.
  function automatic contact_t collide(probe_t p);
    contact_t res;
    longint ax, ay, bx, by, cx, cy, dx, dy, dot_a, dot_b, px, py, ox, oy;
    longint unsigned len2, t, step, d2, s, dist_q, n, r;
    ax = p.sx; ay = p.sy; bx = p.ex; by = p.ey; cx = p.cx; cy = p.cy;
    r = p.r;
    dx = bx - ax; dy = by - ay;
    dot_a = (cx - ax) * dx + (cy - ay) * dy;
    dot_b = (cx - bx) * dx + (cy - by) * dy;
    res = '0;
    if (dot_a <= 0) begin
      px = ax; py = ay;
    end else if (dot_b >= 0) begin
      px = bx; py = by;
    end else begin
      // Projection fraction in Q0.30; dot_a < len2 here, so the quotient fits.
      len2 = dx * dx + dy * dy;
      t = (longint'(dot_a) << 30) / len2;
      step = (abs64(dx) * t + (64'd1 << 29)) >> 30;
      px = ax + ((dx < 0) ? -longint'(step) : longint'(step));
      step = (abs64(dy) * t + (64'd1 << 29)) >> 30;
      py = ay + ((dy < 0) ? -longint'(step) : longint'(step));
    end
    ox = cx - px; oy = cy - py;
    d2 = ox * ox + oy * oy;
    if (d2 > r * r) return res;
    res.hit = 1'b1;
    res.px = px[CB-1:0];
    res.py = py[CB-1:0];
    if (d2 == 0) begin
      // Center on the segment: the direction is undefined, so the normal stays zero.
      res.on_seg = 1'b1;
      res.depth = r[RADIUS_W-1:0];
    end else begin
      s = sqrt_floor(d2 << 28);
      dist_q = (s + 8192) >> 14;
      res.depth = RADIUS_W'(r - dist_q);
      n = ((abs64(ox) << 28) + (s >> 1)) / s;
      if (n > NORM_ONE) n = NORM_ONE;
      res.nx = (ox < 0) ? -NORM_W'(n) : NORM_W'(n);
      n = ((abs64(oy) << 28) + (s >> 1)) / s;
      if (n > NORM_ONE) n = NORM_ONE;
      res.ny = (oy < 0) ? -NORM_W'(n) : NORM_W'(n);
    end
    return res;
  endfunction

  function automatic logic signed [CB-1:0] any_coord();
    return CB'($urandom);
  endfunction

  // A probe that is likely to hit: a short segment with the center placed near its start.
  function automatic probe_t near_probe();
    probe_t p;
    int span, sx, sy;
    span = (($urandom_range(0, 3) == 0) ? 8000 : 1500);
    sx = $urandom_range(0, 40000) - 20000;
    sy = $urandom_range(0, 40000) - 20000;
    p.sx = CB'(sx);
    p.sy = CB'(sy);
    p.ex = CB'(sx + $urandom_range(0, 2 * span) - span);
    p.ey = CB'(sy + $urandom_range(0, 2 * span) - span);
    p.cx = CB'(sx + $urandom_range(0, 4 * span) - span);
    p.cy = CB'(sy + $urandom_range(0, 4 * span) - span);
    p.r  = RADIUS_W'($urandom_range(0, 3 * span));
    return p;
  endfunction

  function automatic probe_t mk(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    probe_t p;
    p.sx = CB'(sx); p.sy = CB'(sy); p.ex = CB'(ex); p.ey = CB'(ey);
    p.cx = CB'(cx); p.cy = CB'(cy); p.r = RADIUS_W'(r);
    return p;
  endfunction

  function automatic probe_t random_probe();
    probe_t p;
    if ($urandom_range(0, 3) == 0) begin
      // Full-range noise, usually a miss, but it exercises every input bit.
      p.sx = any_coord(); p.sy = any_coord(); p.ex = any_coord();
      p.ey = any_coord(); p.cx = any_coord(); p.cy = any_coord();
      p.r = RADIUS_W'($urandom);
    end else begin
      p = near_probe();
      // Occasionally collapse the segment or put the center exactly on an endpoint.
      case ($urandom_range(0, 9))
        0: begin p.ex = p.sx; p.ey = p.sy; end
        1: begin p.cx = p.ex; p.cy = p.ey; end
        2: begin p.cx = p.sx; p.cy = p.sy; end
        default: ;
      endcase
    end
    return p;
  endfunction

  // Driver: offers the head of the pending queue, holding it until the beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      seg_in.valid       <= 1'b0;
      seg_in.seg_start_x <= '0;
      seg_in.seg_start_y <= '0;
      seg_in.seg_end_x   <= '0;
      seg_in.seg_end_y   <= '0;
      seg_in.center_x    <= '0;
      seg_in.center_y    <= '0;
      seg_in.radius      <= '0;
    end else begin
      if (seg_in.valid && seg_in.ready) begin
        expected_contacts.push_back(collide(pending_probes.pop_front()));
      end
      if (!(seg_in.valid && !seg_in.ready)) begin
        if (pending_probes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct
            && !(seg_in.valid && seg_in.ready && pending_probes.size() == 0)) begin
          seg_in.valid       <= 1'b1;
          seg_in.seg_start_x <= pending_probes[0].sx;
          seg_in.seg_start_y <= pending_probes[0].sy;
          seg_in.seg_end_x   <= pending_probes[0].ex;
          seg_in.seg_end_y   <= pending_probes[0].ey;
          seg_in.center_x    <= pending_probes[0].cx;
          seg_in.center_y    <= pending_probes[0].cy;
          seg_in.radius      <= pending_probes[0].r;
        end else begin
          seg_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result beat with the oldest expected contact.
  always @(posedge clk) begin
    contact_t want;
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (expected_contacts.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_contacts.pop_front();
          if (res_out.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, res_out.hit); fail_count++;
          end
          if (res_out.center_on_segment !== want.on_seg) begin
            $error("center_on_segment: expected %0d, got %0d", want.on_seg,
                   res_out.center_on_segment); fail_count++;
          end
          if (res_out.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, res_out.depth); fail_count++;
          end
          if (res_out.normal_x !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, res_out.normal_x);
            fail_count++;
          end
          if (res_out.normal_y !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, res_out.normal_y);
            fail_count++;
          end
          if (res_out.contact_x !== want.px) begin
            $error("contact_x: expected %0d, got %0d", want.px, res_out.contact_x);
            fail_count++;
          end
          if (res_out.contact_y !== want.py) begin
            $error("contact_y: expected %0d, got %0d", want.py, res_out.contact_y);
            fail_count++;
          end
        end
      end
      res_out.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Waits until the driver has handed over every pending probe.
  task automatic wait_sent();
    while (pending_probes.size() > 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (expected_contacts.size() > 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_probes.push_back(random_probe());
    wait_sent();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: clamping to either end, interior projection, a degenerate
    // segment, the center lying on the segment, exact-boundary hits and the
    // extremes of every coordinate and of the radius.
    pending_probes.push_back(mk(0, 0, 2560, 0, -512, 256, 1024));     // clamp to start
    pending_probes.push_back(mk(0, 0, 2560, 0, 3072, 256, 1024));     // clamp to end
    pending_probes.push_back(mk(0, 0, 2560, 0, 1280, 512, 1024));     // interior hit
    pending_probes.push_back(mk(0, 0, 2560, 0, 1280, -512, 256));     // interior miss
    pending_probes.push_back(mk(300, 300, 300, 300, 500, 100, 1000)); // zero length
    pending_probes.push_back(mk(0, 0, 2560, 2560, 1280, 1280, 0));    // center on segment
    pending_probes.push_back(mk(-100, -100, -100, -100, -100, -100, 32767));
    pending_probes.push_back(mk(0, 0, 0, 1000, 300, 500, 300));       // distance equals radius
    pending_probes.push_back(mk(0, 0, 0, 1000, 301, 500, 300));       // just outside
    pending_probes.push_back(mk(0, 0, 1000, 333, 10, 600, 1000));     // rounded projection
    pending_probes.push_back(mk(-32768, -32768, 32767, 32767, 0, 0, 32767));
    pending_probes.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767));
    pending_probes.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 0));
    pending_probes.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    pending_probes.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, 32767));
    pending_probes.push_back(mk(0, 0, 1, 0, 0, 1, 1));                // tiny distances
    pending_probes.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_probes.push_back(mk(1000, -1000, -1000, 1000, 0, 0, 5));  // midpoint on segment
    run_phase(0, 0, 0);
    wait_drained();

    run_phase(0, 0, 120);
    run_phase(85, 0, 90);
    run_phase(0, 85, 90);
    run_phase(35, 35, 100);

    // Long receiver hold-off while the sender keeps offering: the pipeline fills
    // and the input ready must drop.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b1;
    repeat (150) pending_probes.push_back(random_probe());
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    wait_sent();

    // Sender pauses until every expected result has come back, then resumes.
    wait_drained();
    run_phase(0, 0, 20);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_contacts.size() == 0) begin
      $display("segment_circle_collision_core test passed");
    end else begin
      $display("segment_circle_collision_core test failed");
    end
    $finish;
  end

  // Watchdog: about 600 beats, worst-case stalls and the long hold-off fit well inside.
  initial begin
    #3ms;
    $display("segment_circle_collision_core test failed");
    $finish;
  end

endmodule

`default_nettype wire
